// ===== hdl/elc_pkg.sv =====
// Shared types, constants and the divider step function for the ETX link cost block.
package elc_pkg;

	localparam int unsigned DIV_STEPS = 16;

	localparam logic [15:0] COST_INFINITY       = 16'hFFFF;
	localparam logic [15:0] COST_UNIT           = 16'd256;
	localparam logic [15:0] NOMINAL_RX_COST_RST = 16'd256;

	typedef struct packed {
		logic [15:0] divisor;
		logic [14:0] rem;
		logic        nbit;
		logic        ovf;
		logic [15:0] tx;
	} div_in_t;

	typedef struct packed {
		logic [15:0] quo;
		logic        ovf;
		logic [15:0] tx;
	} div_out_t;

	typedef struct packed {
		logic [15:0] divisor;
		logic [14:0] rem;
		logic [15:0] quo;
		logic        nbit;
		logic        ovf;
		logic [15:0] tx;
	} div_stage_t;

	// One restoring step: shift in the next numerator bit, subtract if it fits.
	function automatic div_stage_t div_step(div_stage_t s, logic first);
		div_stage_t n;
		logic [15:0] sh;
		logic        ge;
		n     = s;
		sh    = {s.rem, first ? s.nbit : 1'b0};
		ge    = (sh >= s.divisor);
		n.rem = ge ? 15'(sh - s.divisor) : sh[14:0];
		n.quo = {s.quo[14:0], ge};
		return n;
	endfunction

endpackage

// ===== hdl/elc_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module elc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  elc_pkg::div_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output elc_pkg::div_out_t out_data
);

	localparam int unsigned LAST = elc_pkg::DIV_STEPS - 1;

	elc_pkg::div_stage_t stage_s [elc_pkg::DIV_STEPS];
	logic                vld_s   [elc_pkg::DIV_STEPS];
	logic                rdy     [elc_pkg::DIV_STEPS];
	elc_pkg::div_stage_t head;

	assign head = '{
		divisor: in_data.divisor,
		rem:     in_data.rem,
		quo:     '0,
		nbit:    in_data.nbit,
		ovf:     in_data.ovf,
		tx:      in_data.tx
	};

	for (genvar g = 0; g < elc_pkg::DIV_STEPS; g++) begin : g_step
		elc_pkg::div_stage_t src;
		logic                src_v;

		if (g == 0) begin : g_head
			assign src   = head;
			assign src_v = in_valid;
		end else begin : g_body
			assign src   = stage_s[g-1];
			assign src_v = vld_s[g-1];
		end

		if (g == LAST) begin : g_tail
			assign rdy[g] = !vld_s[g] || out_ready;
		end else begin : g_mid
			assign rdy[g] = !vld_s[g] || rdy[g+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (rdy[g]) begin
				vld_s[g] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g]) begin
				stage_s[g] <= elc_pkg::div_step(src, 1'(g == 0));
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[LAST];
	assign out_data  = '{
		quo: stage_s[LAST].quo,
		ovf: stage_s[LAST].ovf,
		tx:  stage_s[LAST].tx
	};

endmodule

// ===== hdl/etx_link_cost.sv =====
// Top level of the ETX link cost block: history rating, receive cost divider, link cost.
// Pipeline: 1 prep, 16 divider and 3 cost stages from item accepted to result valid.
// Throughput: one item per cycle when not stalled; 16 divider stages, one quotient bit each.
// Each stage holds only while the next is full and stalled, so bubbles close up.
// Reset clears all valid bits and sets the nominal receive cost to 256; data is not reset.
module etx_link_cost (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,      // nominal_rx_cost
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // hello_history [15:0], tx_cost [31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // link_cost [15:0], rx_cost [31:16]
	output logic [0:0]  m_axis_tuser    // cost_infinite [0]
);

	logic [15:0] nominal_q;

	logic              vld_s1;
	elc_pkg::div_in_t  div_s1;
	elc_pkg::div_in_t  prep;
	logic [14:0]       rating;
	logic [15:0]       hist;

	logic              div_in_ready;
	logic              div_out_valid;
	elc_pkg::div_out_t div_out;

	logic        vld_s2;
	logic [15:0] rx_s2;
	logic [15:0] tx_s2;

	logic        vld_s3;
	logic [31:0] prod_s3;
	logic [15:0] rx_s3;
	logic [15:0] tx_s3;
	logic        rx_inf_s3;
	logic        small_s3;
	logic [15:0] mul_a;
	logic [15:0] mul_b;

	logic        vld_s4;
	logic [15:0] link_s4;
	logic [15:0] rx_s4;
	logic        inf_s4;
	logic [23:0] scaled;
	logic [15:0] cost;

	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;
	logic rdy_s4;

	assign rdy_s4 = !vld_s4 || m_axis_tready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || div_in_ready;

	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= elc_pkg::NOMINAL_RX_COST_RST;
		end else if (cfg_we) begin
			nominal_q <= cfg_wdata;
		end
	end

	// Rate the history; overflow when the quotient cannot fit in 16 bits.
	always_comb begin
		hist         = s_axis_tdata[15:0];
		rating       = 15'({1'b0, hist[15], 13'd0}) + 15'({1'b0, hist[14], 13'd0})
			+ 15'(hist[13:0]);
		prep.divisor = 16'(rating) + 16'd1;
		prep.rem     = nominal_q[15:1];
		prep.nbit    = nominal_q[0];
		prep.ovf     = ({1'b0, nominal_q[15:1]} >= prep.divisor);
		prep.tx      = s_axis_tdata[31:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			div_s1 <= prep;
		end
	end

	elc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (div_in_ready),
		.in_data   (div_s1),
		.out_valid (div_out_valid),
		.out_ready (rdy_s2),
		.out_data  (div_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				vld_s2 <= div_out_valid;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			rx_s2 <= (div_out.ovf || div_out.quo >= elc_pkg::COST_INFINITY)
				? elc_pkg::COST_INFINITY : div_out.quo;
			tx_s2 <= div_out.tx;
		end
	end

	assign mul_a = (tx_s2 < elc_pkg::COST_UNIT) ? elc_pkg::COST_UNIT : tx_s2;
	assign mul_b = (rx_s2 < elc_pkg::COST_UNIT) ? elc_pkg::COST_UNIT : rx_s2;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			prod_s3   <= 32'(mul_a) * 32'(mul_b);
			rx_s3     <= rx_s2;
			tx_s3     <= tx_s2;
			rx_inf_s3 <= (rx_s2 == elc_pkg::COST_INFINITY);
			small_s3  <= (tx_s2 < elc_pkg::COST_UNIT) && (rx_s2 < elc_pkg::COST_UNIT);
		end
	end

	always_comb begin
		scaled = prod_s3[31:8];
		if (rx_inf_s3) begin
			cost = elc_pkg::COST_INFINITY;
		end else if (small_s3) begin
			cost = tx_s3;
		end else if (scaled >= 24'(elc_pkg::COST_INFINITY)) begin
			cost = elc_pkg::COST_INFINITY;
		end else begin
			cost = scaled[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			link_s4 <= cost;
			rx_s4   <= rx_s3;
			inf_s4  <= (cost == elc_pkg::COST_INFINITY);
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {rx_s4, link_s4};
	assign m_axis_tuser  = inf_s4;

endmodule

// ===== hdl/elc_checker.sv =====
// Port-level checks for the ETX link cost block, bound to the top level.
module elc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser
);

	// Hold a stalled item.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output item changed");

	a_inf_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			m_axis_tuser[0] == (m_axis_tdata[15:0] == elc_pkg::COST_INFINITY))
		else $error("infinity flag disagrees with link cost");

	a_rx_inf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[31:16] == elc_pkg::COST_INFINITY |->
			m_axis_tdata[15:0] == elc_pkg::COST_INFINITY)
		else $error("infinite receive cost gave finite link cost");

	a_no_out_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid straight after reset");

endmodule

bind etx_link_cost elc_checker u_elc_checker (.*);

// ===== verif/tb_etx_link_cost.sv =====
// Testbench for etx_link_cost: random and directed neighbour entries, checked against a predictor.
module tb_etx_link_cost;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES         = 10;
	localparam int ITEMS_PER_PHASE = 140;

	typedef struct packed {
		logic [15:0] tx_cost;
		logic [15:0] hello_history;
	} neighbour_t;

	typedef struct packed {
		logic [15:0] link_cost;
		logic [15:0] rx_cost;
		logic        cost_infinite;
	} link_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;     // hello_history [15:0], tx_cost [31:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // link_cost [15:0], rx_cost [31:16]
	logic [0:0]  m_axis_tuser;          // cost_infinite [0]

	neighbour_t   pending_items[$];
	link_result_t predicted_costs[$];
	logic [15:0]  nominal_cost = elc_pkg::NOMINAL_RX_COST_RST;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;
	int unsigned  hold_requests = 0;
	int unsigned  hold_seen = 0;
	int unsigned  hold_left = 0;
	int unsigned  stall_cycles = 0;
	int unsigned  fail_count = 0;

	etx_link_cost dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic link_result_t predict_link_cost(logic [15:0] hist, logic [15:0] tx,
			logic [15:0] nominal);
		logic [63:0] rating;
		logic [63:0] quot;
		logic [63:0] tx_term;
		logic [63:0] rx_term;
		logic [63:0] prod;
		link_result_t r;
		rating = (64'(hist[15]) << 13) + (64'(hist[14]) << 13) + 64'(hist[13:0]);
		quot = (64'h8000 * 64'(nominal)) / (rating + 64'd1);
		r.rx_cost = (quot >= 64'(elc_pkg::COST_INFINITY)) ? elc_pkg::COST_INFINITY : quot[15:0];
		if (r.rx_cost == elc_pkg::COST_INFINITY) begin
			r.link_cost = elc_pkg::COST_INFINITY;
		end else if (tx < elc_pkg::COST_UNIT && r.rx_cost < elc_pkg::COST_UNIT) begin
			r.link_cost = tx;
		end else begin
			tx_term = (tx < elc_pkg::COST_UNIT) ? 64'(elc_pkg::COST_UNIT) : 64'(tx);
			rx_term = (r.rx_cost < elc_pkg::COST_UNIT) ? 64'(elc_pkg::COST_UNIT)
				: 64'(r.rx_cost);
			prod = (tx_term * rx_term) >> 8;
			r.link_cost = (prod >= 64'(elc_pkg::COST_INFINITY)) ? elc_pkg::COST_INFINITY
				: prod[15:0];
		end
		r.cost_infinite = (r.link_cost == elc_pkg::COST_INFINITY);
		return r;
	endfunction

	function automatic logic [15:0] random_history();
		logic [15:0] h;
		case ($urandom_range(4))
			0: begin
				h = 16'($urandom);
			end
			1: begin
				h = 16'($urandom | $urandom);
			end
			2: begin
				h = ~16'($urandom & $urandom & $urandom);
			end
			3: begin
				h = 16'($urandom & $urandom & $urandom);
			end
			default: begin
				case ($urandom_range(5))
					0: h = 16'h0000;
					1: h = 16'hFFFF;
					2: h = 16'h8000;
					3: h = 16'h4000;
					4: h = 16'h3FFF;
					default: h = 16'hC000;
				endcase
			end
		endcase
		return h;
	endfunction

	function automatic logic [15:0] random_tx();
		logic [15:0] t;
		case ($urandom_range(3))
			0: t = 16'($urandom_range(255));
			1: t = 16'($urandom_range(400, 200));
			2: t = 16'($urandom);
			default: begin
				case ($urandom_range(3))
					0: t = 16'h0000;
					1: t = elc_pkg::COST_UNIT - 16'd1;
					2: t = elc_pkg::COST_UNIT;
					default: t = elc_pkg::COST_INFINITY;
				endcase
			end
		endcase
		return t;
	endfunction

	task automatic queue_item(logic [15:0] hist, logic [15:0] tx);
		neighbour_t n;
		n.hello_history = hist;
		n.tx_cost = tx;
		pending_items.push_back(n);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_axis_tvalid || predicted_costs.size() != 0)
			@(negedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_nominal(logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 16'($urandom);
		nominal_cost = value;
	endtask

	// sender: offer the next pending item when the slot frees up
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted_costs.push_back(predict_link_cost(s_axis_tdata[15:0],
					s_axis_tdata[31:16], nominal_cost));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tdata <= pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		link_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (predicted_costs.size() == 0) begin
				$error("unexpected result item: link_cost %0d rx_cost %0d",
					m_axis_tdata[15:0], m_axis_tdata[31:16]);
				fail_count++;
			end else begin
				want = predicted_costs.pop_front();
				if (m_axis_tdata[15:0] !== want.link_cost) begin
					$error("link_cost mismatch: expected %0d, actual %0d",
						want.link_cost, m_axis_tdata[15:0]);
					fail_count++;
				end
				if (m_axis_tdata[31:16] !== want.rx_cost) begin
					$error("rx_cost mismatch: expected %0d, actual %0d",
						want.rx_cost, m_axis_tdata[31:16]);
					fail_count++;
				end
				if (m_axis_tuser[0] !== want.cost_infinite) begin
					$error("cost_infinite mismatch: expected %0d, actual %0d",
						want.cost_infinite, m_axis_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(pending_items.size() == 0 && !s_axis_tvalid && predicted_costs.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [15:0] phase_nominal [PHASES];
		phase_nominal = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd255, 16'd300, 16'd512,
			16'd4096, 16'($urandom), 16'($urandom)};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 12;
				recv_idle_pct = 65;
			end else if (p < 7) begin
				send_idle_pct = 65;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p != 0)
				write_nominal(phase_nominal[p]);
			case (p)
				0: begin
					queue_item(16'h0000, 16'd256);
					queue_item(16'hFFFF, 16'd256);
					queue_item(16'hFFFF, 16'd0);
					queue_item(16'hFFFF, 16'hFFFF);
					queue_item(16'hC000, 16'd255);
					queue_item(16'h3FFF, 16'd257);
					queue_item(16'h8000, 16'd1000);
					queue_item(16'h4000, 16'd256);
					queue_item(16'h007F, 16'd256);
					queue_item(16'h0080, 16'd256);
				end
				1: begin
					queue_item(16'h0000, 16'd0);
					queue_item(16'hFFFF, 16'd255);
					queue_item(16'h1234, 16'd256);
					queue_item(16'h0000, 16'hFFFF);
				end
				2: begin
					queue_item(16'hFFFF, 16'd256);
					queue_item(16'hFFFF, 16'd0);
					queue_item(16'h0000, 16'd0);
				end
				4: begin
					queue_item(16'hFFFF, 16'd100);
					queue_item(16'hFFFF, 16'd300);
					queue_item(16'h7FFF, 16'd255);
				end
				default: begin
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				queue_item(random_history(), random_tx());
			// hold the output long enough to back the pipeline up into the input
			if (p == 0 || p == 7)
				hold_requests++;
			wait_drained();
		end
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
